// ===== rtl/rtqu_pkg.sv =====
package rtqu_pkg;

    localparam int IDX_W = 6;   // slot index, up to 64 slots
    localparam int CNT_W = 9;   // live and due counts

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FIRED     = 3'd3;
    localparam logic [2:0] ST_IDLE_TICK = 3'd4;

    localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        PR_CREATE = 2'd0,
        PR_DELETE = 2'd1,
        PR_MARK   = 2'd2,
        PR_PICK   = 2'd3
    } probe_kind_t;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIRE   = 2'd2
    } cmd_kind_t;

    // Search record that walks the row of slots, one slot a cycle.
    typedef struct packed {
        logic              valid;
        probe_kind_t       kind;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [47:0]       deadline;
        logic [31:0]       id;
        logic              freed;
        logic [CNT_W-1:0]  live_cnt;
        logic [CNT_W-1:0]  due_cnt;
    } probe_t;

    // Update sent to every slot; only the addressed one acts.
    typedef struct packed {
        logic              valid;
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       id;
    } cmd_t;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[48] ? TIME_MAX : s[47:0];
    endfunction

endpackage

// ===== rtl/rtqu_if.sv =====
interface rtqu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] first_offset;
    logic [31:0] reload_interval;
    logic signed [31:0] repeat_total;
    logic [31:0] target_id;

    modport source(output valid, op, first_offset, reload_interval, repeat_total, target_id,
                   input ready);
    modport sink(input valid, op, first_offset, reload_interval, repeat_total, target_id,
                 output ready);
endinterface

interface rtqu_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] new_id;
    logic [31:0] fired_id;
    logic        last;
    logic [8:0]  active_count;

    modport source(output valid, status, new_id, fired_id, last, active_count, input ready);
    modport sink(input valid, status, new_id, fired_id, last, active_count, output ready);
endinterface

// ===== rtl/rtqu_cell.sv =====
module rtqu_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtqu_pkg::probe_t    probe_in,
    output rtqu_pkg::probe_t    probe_out,
    input  rtqu_pkg::cmd_t      cmd,
    input  logic [47:0]         now,
    input  logic [31:0]         first_offset,
    input  logic [31:0]         reload_interval,
    input  logic [31:0]         rem_init,
    input  logic [31:0]         target_id
);

    logic              live_reg;
    logic              due_reg;
    logic [31:0]       id_reg;
    logic [47:0]       dl_reg;
    logic [31:0]       ivl_reg;
    logic [31:0]       rem_reg;
    rtqu_pkg::probe_t  probe_reg;
    rtqu_pkg::probe_t  probe_next;
    logic              mine;

    assign mine      = cmd.valid && (cmd.idx == rtqu_pkg::IDX_W'(IDX));
    assign probe_out = probe_reg;

    always_comb
    begin
        probe_next = probe_in;
        probe_next.live_cnt = probe_in.live_cnt + rtqu_pkg::CNT_W'(live_reg);
        unique case (probe_in.kind)
            rtqu_pkg::PR_CREATE:
            begin
                if (!probe_in.hit && !live_reg)
                begin
                    probe_next.hit = 1'b1;
                    probe_next.idx = rtqu_pkg::IDX_W'(IDX);
                end
            end
            rtqu_pkg::PR_DELETE:
            begin
                if (!probe_in.hit && live_reg && id_reg == target_id)
                begin
                    probe_next.hit = 1'b1;
                    probe_next.idx = rtqu_pkg::IDX_W'(IDX);
                end
            end
            rtqu_pkg::PR_MARK:
            begin
                if (live_reg && dl_reg <= now)
                    probe_next.due_cnt = probe_in.due_cnt + 1'b1;
            end
            rtqu_pkg::PR_PICK:
            begin
                // strict less keeps the lower slot on equal deadlines
                if (due_reg && (!probe_in.hit || dl_reg < probe_in.deadline))
                begin
                    probe_next.hit      = 1'b1;
                    probe_next.idx      = rtqu_pkg::IDX_W'(IDX);
                    probe_next.deadline = dl_reg;
                    probe_next.id       = id_reg;
                    probe_next.freed    = (rem_reg == 32'd1);
                end
            end
            default: probe_next = probe_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= 1'b0;
            due_reg   <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (probe_in.valid && probe_in.kind == rtqu_pkg::PR_MARK)
                due_reg <= live_reg && (dl_reg <= now);
            if (mine)
            begin
                unique case (cmd.kind)
                    rtqu_pkg::CMD_CREATE: live_reg <= 1'b1;
                    rtqu_pkg::CMD_DELETE: live_reg <= 1'b0;
                    rtqu_pkg::CMD_FIRE:
                    begin
                        due_reg <= 1'b0;
                        if (rem_reg == 32'd1)
                            live_reg <= 1'b0;
                    end
                    default: live_reg <= live_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mine)
        begin
            unique case (cmd.kind)
                rtqu_pkg::CMD_CREATE:
                begin
                    id_reg  <= cmd.id;
                    dl_reg  <= rtqu_pkg::sat_add48(now, first_offset);
                    ivl_reg <= reload_interval;
                    rem_reg <= rem_init;
                end
                rtqu_pkg::CMD_FIRE:
                begin
                    if (rem_reg != rtqu_pkg::FOREVER)
                        rem_reg <= rem_reg - 32'd1;
                    dl_reg <= rtqu_pkg::sat_add48(now, ivl_reg);
                end
                default: dl_reg <= dl_reg;
            endcase
        end
    end

endmodule

// ===== rtl/repeating_timer_queue_unit.sv =====
// Timer queue over a row of SLOTS timer slots and a saturating millisecond count.
// Every create, delete and tick sends a search record down the row of slots, one
// slot per cycle. A tick takes one marking pass that flags the due timers, then
// one selection pass per fired timer (earliest deadline, then lowest slot), and
// gives one result per fired timer or a single "nothing due" result. Op code 3
// is taken and dropped without a result. A finished result waits in the output
// register while the next item is accepted. Slot contents need no clearing.
module repeating_timer_queue_unit #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rtqu_in_if.sink       item_in,
    rtqu_out_if.source    result_out
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_NEXT   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    logic [47:0]               now_reg;
    logic [31:0]               id_counter_reg;
    rtqu_pkg::probe_kind_t     kind_reg;
    logic [31:0]               offset_reg, interval_reg, rem_reg, target_reg;
    logic [rtqu_pkg::CNT_W-1:0] due_left_reg;
    rtqu_pkg::probe_t          hold_reg;
    rtqu_pkg::probe_t          launch;
    rtqu_pkg::probe_t          chain [SLOTS+1];
    rtqu_pkg::cmd_t            cmd;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [31:0] out_new_id_reg, out_fired_id_reg;
    logic        out_last_reg;
    logic [8:0]  out_active_reg;

    logic        in_acc;
    logic        emit_ok;
    logic        emit_now;
    logic [31:0] rep_norm;

    assign item_in.ready = (state_reg == S_IDLE);
    assign in_acc        = item_in.valid && item_in.ready;
    assign emit_ok       = !out_valid_reg || result_out.ready;
    // load a result into the output register, except after a marking pass with work to do
    assign emit_now      = (state_reg == S_DECIDE) && emit_ok
                           && !(hold_reg.kind == rtqu_pkg::PR_MARK && hold_reg.due_cnt != '0);

    assign result_out.valid        = out_valid_reg;
    assign result_out.status       = out_status_reg;
    assign result_out.new_id       = out_new_id_reg;
    assign result_out.fired_id     = out_fired_id_reg;
    assign result_out.last         = out_last_reg;
    assign result_out.active_count = out_active_reg;

    // forever stays, zero and negative counts give one firing
    always_comb
    begin
        if (item_in.repeat_total == -32'sd1)
            rep_norm = rtqu_pkg::FOREVER;
        else if (item_in.repeat_total <= 32'sd0)
            rep_norm = 32'd1;
        else
            rep_norm = 32'(item_in.repeat_total);
    end

    // launch a fresh search record into the first slot
    always_comb
    begin
        launch       = '0;
        launch.valid = (state_reg == S_NEXT);
        launch.kind  = kind_reg;
    end

    assign chain[0] = launch;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rtqu_cell #(.IDX(g)) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .probe_in        (chain[g]),
            .probe_out       (chain[g+1]),
            .cmd             (cmd),
            .now             (now_reg),
            .first_offset    (offset_reg),
            .reload_interval (interval_reg),
            .rem_init        (rem_reg),
            .target_id       (target_reg)
        );
    end

    // slot update issued when the result of a pass is released
    always_comb
    begin
        cmd       = '0;
        cmd.idx   = hold_reg.idx;
        cmd.id    = id_counter_reg;
        cmd.kind  = rtqu_pkg::CMD_FIRE;
        if (state_reg == S_DECIDE && emit_ok && hold_reg.hit)
        begin
            unique case (hold_reg.kind)
                rtqu_pkg::PR_CREATE: begin cmd.valid = 1'b1; cmd.kind = rtqu_pkg::CMD_CREATE; end
                rtqu_pkg::PR_DELETE: begin cmd.valid = 1'b1; cmd.kind = rtqu_pkg::CMD_DELETE; end
                rtqu_pkg::PR_PICK:   begin cmd.valid = 1'b1; cmd.kind = rtqu_pkg::CMD_FIRE;   end
                default:             cmd.valid = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (item_in.op == rtqu_pkg::OP_CREATE
                    || item_in.op == rtqu_pkg::OP_DELETE || item_in.op == rtqu_pkg::OP_TICK))
                    state_next = S_NEXT;
            end
            S_NEXT: state_next = S_SCAN;
            S_SCAN:
            begin
                if (chain[SLOTS].valid)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (hold_reg.kind == rtqu_pkg::PR_MARK && hold_reg.due_cnt != '0)
                    state_next = S_NEXT;
                else if (emit_ok)
                begin
                    if (hold_reg.kind == rtqu_pkg::PR_PICK
                        && due_left_reg > rtqu_pkg::CNT_W'(1))
                        state_next = S_NEXT;
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            id_counter_reg <= 32'd1;
            kind_reg       <= rtqu_pkg::PR_CREATE;
            due_left_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_now)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result_out.ready)
                out_valid_reg <= 1'b0;

            if (in_acc)
            begin
                unique case (item_in.op)
                    rtqu_pkg::OP_CREATE: kind_reg <= rtqu_pkg::PR_CREATE;
                    rtqu_pkg::OP_DELETE: kind_reg <= rtqu_pkg::PR_DELETE;
                    rtqu_pkg::OP_TICK:
                    begin
                        kind_reg <= rtqu_pkg::PR_MARK;
                        if (now_reg != rtqu_pkg::TIME_MAX)
                            now_reg <= now_reg + 48'd1;
                    end
                    default: kind_reg <= kind_reg;
                endcase
            end

            if (state_reg == S_DECIDE)
            begin
                if (hold_reg.kind == rtqu_pkg::PR_MARK && hold_reg.due_cnt != '0)
                begin
                    due_left_reg <= hold_reg.due_cnt;
                    kind_reg     <= rtqu_pkg::PR_PICK;
                end
                else if (emit_ok)
                begin
                    if (hold_reg.kind == rtqu_pkg::PR_CREATE && hold_reg.hit)
                        id_counter_reg <= id_counter_reg + 32'd1;
                    if (hold_reg.kind == rtqu_pkg::PR_PICK)
                        due_left_reg <= due_left_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            offset_reg   <= item_in.first_offset;
            interval_reg <= item_in.reload_interval;
            rem_reg      <= rep_norm;
            target_reg   <= item_in.target_id;
        end
        if (state_reg == S_SCAN && chain[SLOTS].valid)
            hold_reg <= chain[SLOTS];
        if (emit_now)
        begin
            out_new_id_reg   <= '0;
            out_fired_id_reg <= '0;
            out_last_reg     <= 1'b1;
            out_active_reg   <= hold_reg.live_cnt;
            unique case (hold_reg.kind)
                rtqu_pkg::PR_CREATE:
                begin
                    out_status_reg <= hold_reg.hit ? rtqu_pkg::ST_OK : rtqu_pkg::ST_FULL;
                    if (hold_reg.hit)
                    begin
                        out_new_id_reg <= id_counter_reg;
                        out_active_reg <= hold_reg.live_cnt + 1'b1;
                    end
                end
                rtqu_pkg::PR_DELETE:
                begin
                    out_status_reg <= hold_reg.hit ? rtqu_pkg::ST_OK : rtqu_pkg::ST_NOT_FOUND;
                    if (hold_reg.hit)
                        out_active_reg <= hold_reg.live_cnt - 1'b1;
                end
                rtqu_pkg::PR_MARK: out_status_reg <= rtqu_pkg::ST_IDLE_TICK;
                rtqu_pkg::PR_PICK:
                begin
                    out_status_reg   <= rtqu_pkg::ST_FIRED;
                    out_fired_id_reg <= hold_reg.id;
                    out_last_reg     <= (due_left_reg == rtqu_pkg::CNT_W'(1));
                    out_active_reg   <= hold_reg.live_cnt - rtqu_pkg::CNT_W'(hold_reg.freed);
                end
                default: out_status_reg <= rtqu_pkg::ST_OK;
            endcase
        end
    end

    a_cmd_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> state_reg == S_DECIDE)
        else $error("slot update outside decide");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[SLOTS].valid |-> state_reg == S_SCAN)
        else $error("search record left the row outside scan");

    a_idle_no_due: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> due_left_reg == '0)
        else $error("due timers left when idle");

    a_accept_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && item_in.op == rtqu_pkg::OP_TICK) |=> state_reg == S_NEXT
            && kind_reg == rtqu_pkg::PR_MARK)
        else $error("tick did not start a marking pass");

endmodule

// ===== tb/repeating_timer_queue_unit_tb.sv =====
module repeating_timer_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] new_id;
        logic [31:0] fired_id;
        logic        last;
        logic [8:0]  active_count;
    } timer_result_t;

    // Tracks the timer table and holds the results still owed by the block.
    class timer_scoreboard;
        logic [47:0] now_ms;
        logic [31:0] next_id;
        bit          live[SLOTS];
        logic [31:0] ids[SLOTS];
        logic [47:0] deadline[SLOTS];
        logic [31:0] interval[SLOTS];
        logic [31:0] remaining[SLOTS];
        timer_result_t owed[$];
        int errors;
        int results_seen;
        int fired_seen;
        int full_seen;

        function new();
            now_ms = '0;
            next_id = 32'd1;
            foreach (live[i]) live[i] = 1'b0;
            errors = 0;
            results_seen = 0;
            fired_seen = 0;
            full_seen = 0;
        endfunction

        function logic [8:0] live_timers();
            logic [8:0] n;
            n = '0;
            foreach (live[i]) if (live[i]) n++;
            return n;
        endfunction

        function logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {17'd0, b};
            return s[48] ? rtqu_pkg::TIME_MAX : s[47:0];
        endfunction

        function void owe(logic [2:0] st, logic [31:0] nid, logic [31:0] fid, logic lst);
            timer_result_t r;
            r.status = st;
            r.new_id = nid;
            r.fired_id = fid;
            r.last = lst;
            r.active_count = live_timers();
            owed.push_back(r);
        endfunction

        // Pick an id worth deleting: mostly a live one.
        function logic [31:0] some_live_id();
            int picks[$];
            foreach (live[i]) if (live[i]) picks.push_back(i);
            if (picks.size() == 0 || $urandom_range(9) < 2)
                return ($urandom_range(1) == 1) ? $urandom : next_id - $urandom_range(1, 4);
            return ids[picks[$urandom_range(picks.size() - 1)]];
        endfunction

        function void note_item(logic [1:0] op, logic [31:0] offset, logic [31:0] ivl,
                                logic [31:0] reps, logic [31:0] target);
            int free_slot;
            int best;
            int n_due;
            bit due[SLOTS];
            free_slot = -1;
            best = -1;
            n_due = 0;
            case (op)
                rtqu_pkg::OP_CREATE:
                begin
                    for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) free_slot = i;
                    if (free_slot < 0)
                    begin
                        owe(rtqu_pkg::ST_FULL, '0, '0, 1'b1);
                        return;
                    end
                    live[free_slot] = 1'b1;
                    ids[free_slot] = next_id;
                    deadline[free_slot] = add_sat(now_ms, offset);
                    interval[free_slot] = ivl;
                    if (reps == rtqu_pkg::FOREVER)
                        remaining[free_slot] = rtqu_pkg::FOREVER;
                    else if (reps == 0 || reps[31])
                        remaining[free_slot] = 32'd1;
                    else
                        remaining[free_slot] = reps;
                    next_id = next_id + 32'd1;
                    owe(rtqu_pkg::ST_OK, ids[free_slot], '0, 1'b1);
                end
                rtqu_pkg::OP_DELETE:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (live[i] && ids[i] == target)
                        begin
                            live[i] = 1'b0;
                            owe(rtqu_pkg::ST_OK, '0, '0, 1'b1);
                            return;
                        end
                    end
                    owe(rtqu_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
                rtqu_pkg::OP_TICK:
                begin
                    if (now_ms != rtqu_pkg::TIME_MAX) now_ms++;
                    foreach (due[i])
                    begin
                        due[i] = live[i] && deadline[i] <= now_ms;
                        if (due[i]) n_due++;
                    end
                    if (n_due == 0)
                    begin
                        owe(rtqu_pkg::ST_IDLE_TICK, '0, '0, 1'b1);
                        return;
                    end
                    // Earliest deadline first; ties go to the lowest slot.
                    for (int k = 0; k < n_due; k++)
                    begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (due[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
                        due[best] = 1'b0;
                        if (remaining[best] != rtqu_pkg::FOREVER)
                        begin
                            remaining[best]--;
                            if (remaining[best] == 0) live[best] = 1'b0;
                        end
                        if (live[best]) deadline[best] = add_sat(now_ms, interval[best]);
                        owe(rtqu_pkg::ST_FIRED, '0, ids[best], k == n_due - 1);
                    end
                end
                default: ;  // unused code: dropped, nothing owed
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        endtask

        task check_result(timer_result_t got);
            timer_result_t want;
            results_seen++;
            if (owed.size() == 0)
            begin
                report("unexpected result, status", got.status, '0);
                return;
            end
            want = owed.pop_front();
            if (got.status == rtqu_pkg::ST_FIRED) fired_seen++;
            if (got.status == rtqu_pkg::ST_FULL) full_seen++;
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.new_id !== want.new_id) report("new_id", got.new_id, want.new_id);
            if (got.fired_id !== want.fired_id) report("fired_id", got.fired_id, want.fired_id);
            if (got.last !== want.last) report("last", got.last, want.last);
            if (got.active_count !== want.active_count)
                report("active_count", got.active_count, want.active_count);
        endtask
    endclass

    logic clk;
    logic rst_n;

    rtqu_in_if  in_if();
    rtqu_out_if out_if();

    repeating_timer_queue_unit #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (in_if),
        .result_out(out_if)
    );

    timer_scoreboard timers = new();

    int src_idle_pct;
    int snk_idle_pct;
    int hold_requests;
    int items_sent;
    int quiet_cycles;

    always #5 clk = ~clk;

    // Drive every input to a known value from time zero.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = '0;
        in_if.first_offset = '0;
        in_if.reload_interval = '0;
        in_if.repeat_total = '0;
        in_if.target_id = '0;
        out_if.ready = 1'b0;
        src_idle_pct = 22;
        snk_idle_pct = 70;
        hold_requests = 0;
        items_sent = 0;
        quiet_cycles = 0;
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks.
    initial
    begin : receiver
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready = 1'b0;
            end
            else
            begin
                out_if.ready = rst_n && ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Sample both handshakes at the rising edge; also watch for a hung block.
    always @(posedge clk)
    begin
        timer_result_t r;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_if.valid && in_if.ready)
            begin
                quiet_cycles = 0;
                timers.note_item(in_if.op, in_if.first_offset, in_if.reload_interval,
                                 in_if.repeat_total, in_if.target_id);
            end
            if (out_if.valid && out_if.ready)
            begin
                quiet_cycles = 0;
                r.status = out_if.status;
                r.new_id = out_if.new_id;
                r.fired_id = out_if.fired_id;
                r.last = out_if.last;
                r.active_count = out_if.active_count;
                timers.check_result(r);
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                         quiet_cycles, timers.owed.size());
                $display("repeating_timer_queue_unit regression: fail");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the block takes it.
    task send_item(logic [1:0] op, logic [31:0] offset, logic [31:0] ivl,
                   logic [31:0] reps, logic [31:0] target);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.op = op;
        in_if.first_offset = offset;
        in_if.reload_interval = ivl;
        in_if.repeat_total = reps;
        in_if.target_id = target;
        in_if.valid = 1'b1;
        do @(posedge clk); while (!in_if.ready);
        @(negedge clk);
        items_sent++;
    endtask

    task drain();
        in_if.valid = 1'b0;
        while (timers.owed.size() != 0) @(negedge clk);
    endtask

    // One random item; small offsets and intervals keep timers firing often.
    task random_item();
        int pick;
        logic [31:0] offset;
        logic [31:0] ivl;
        logic [31:0] reps;
        pick = $urandom_range(99);
        offset = ($urandom_range(9) < 8) ? $urandom_range(0, 6) : $urandom;
        ivl = ($urandom_range(9) < 8) ? $urandom_range(0, 5) : $urandom;
        case ($urandom_range(9))
            0, 1:    reps = rtqu_pkg::FOREVER;
            2:       reps = 32'd0;
            3:       reps = $urandom | 32'h8000_0000;
            4:       reps = $urandom & 32'h7FFF_FFFF;
            default: reps = $urandom_range(1, 4);
        endcase
        if (pick < 40)
            send_item(rtqu_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 75)
            send_item(rtqu_pkg::OP_CREATE, offset, ivl, reps, $urandom);
        else if (pick < 95)
            send_item(rtqu_pkg::OP_DELETE, $urandom, $urandom, $urandom, timers.some_live_id());
        else
            send_item(rtqu_pkg::OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: nothing due, forever timer with zero interval, count edge values.
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_CREATE, '0, '0, rtqu_pkg::FOREVER, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(rtqu_pkg::OP_CREATE, 32'd1, 32'd2, 32'd0, '0);
        send_item(rtqu_pkg::OP_CREATE, 32'd2, 32'd0, 32'h8000_0000, '0);
        send_item(rtqu_pkg::OP_CREATE, 32'd1, 32'd1, 32'hFFFF_FFFB, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_DELETE, '0, '0, '0, 32'd1);
        send_item(rtqu_pkg::OP_DELETE, '0, '0, '0, 32'd1);
        send_item(rtqu_pkg::OP_DELETE, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(rtqu_pkg::OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        // Fill the table to exactly full, then let many fire on one tick with tied deadlines.
        for (int i = 0; i < 15; i++)
            send_item(rtqu_pkg::OP_CREATE, i % 3, 32'd1, (i % 2) + 1, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_TICK, '0, '0, '0, '0);
        send_item(rtqu_pkg::OP_DELETE, '0, '0, '0, 32'd2);
        drain();

        // Random phase one: sender lightly idle, receiver mostly stalled.
        repeat (100) random_item();
        drain();

        // Phase two: the other way round.
        src_idle_pct = 70;
        snk_idle_pct = 22;
        repeat (100) random_item();
        // Pause the sender until every owed result has come back.
        drain();

        // Phase three: no idling, and a long receiver hold-off to back up the block.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_requests++;
        repeat (40) random_item();
        repeat (60) random_item();
        drain();

        repeat (200) @(posedge clk);
        $display("ran %0d items: %0d results checked, %0d timer firings, %0d table-full",
                 items_sent, timers.results_seen, timers.fired_seen, timers.full_seen);
        $display("phases covered sender and receiver stalls, a long hold-off and no idling");
        if (timers.errors == 0 && timers.owed.size() == 0)
        begin
            $display("repeating_timer_queue_unit regression: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d results never came", timers.errors,
                     timers.owed.size());
            $display("repeating_timer_queue_unit regression: fail");
        end
        $finish;
    end
endmodule

// ===== repeating_timer_queue_unit.f =====
rtl/rtqu_pkg.sv
rtl/rtqu_if.sv
rtl/rtqu_cell.sv
rtl/repeating_timer_queue_unit.sv
tb/repeating_timer_queue_unit_tb.sv
